[hdl/assert_macros.svh]
// Assertion macros shared by the collator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BKC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// The condition must never be seen outside reset.
`define BKC_NEVER(label, cond) \
  `BKC_ASSERT(label, !(cond))

`endif

[hdl/bkc_pkg.sv]
// Types and constants of the advertising key collator.
package bkc_pkg;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BYTE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  localparam logic [2:0] ST_NAME    = 3'd0;
  localparam logic [2:0] ST_NO_KEY  = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_UPDATED = 3'd3;
  localparam logic [2:0] ST_CREATED = 3'd4;
  localparam logic [2:0] ST_FULL    = 3'd5;
  localparam logic [2:0] ST_READ    = 3'd6;

  localparam logic [7:0]  TYPE_FLAGS      = 8'h01;
  localparam logic [7:0]  TYPE_SHORT_NAME = 8'h08;
  localparam logic [7:0]  TYPE_FULL_NAME  = 8'h09;
  localparam logic [15:0] HITS_MAX        = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    kind_t       kind;
    logic [47:0] address;
    logic [15:0] key;
    logic [7:0]  ptype;
    logic [7:0]  length;
    logic [5:0]  device_index;
    logic [3:0]  slot_index;
    logic [4:0]  byte_index;
  } request_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] hits;
    logic [7:0]  length;
  } slot_entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DISPATCH,
    B_READ_WAIT,
    B_LOOKUP_RD,
    B_LOOKUP_CMP,
    B_USED_RD,
    B_SLOT_START,
    B_SLOT_CHECK,
    B_SLOT_CMP,
    B_DECIDE,
    B_COPY_RD,
    B_COPY_WR
  } back_state_t;

endpackage

[hdl/bkc_queue.sv]
// Short request queue between the front parser and the back sequencer.
`include "assert_macros.svh"
module bkc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bkc_pkg::request_t push_data,
  input  logic              pop,
  output bkc_pkg::request_t head,
  output logic              empty,
  output logic              full
);

  localparam int AW = (bkc_pkg::QUEUE_DEPTH > 1) ? $clog2(bkc_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(bkc_pkg::QUEUE_DEPTH + 1);

  bkc_pkg::request_t entries [bkc_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(bkc_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(bkc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(bkc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BKC_NEVER(queue_no_overflow, push && full && !pop)
  `BKC_NEVER(queue_no_underflow, pop && empty)

endmodule

[hdl/bkc_front.sv]
// Front parser: takes requests, walks the length/type structures and buffers the packet.
module bkc_front #(
  parameter int PAYLOAD_BYTES = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [47:0]       address,
  input  logic [7:0]        data_byte,
  input  logic              last,
  input  logic [5:0]        device_index,
  input  logic [3:0]        slot_index,
  input  logic [4:0]        byte_index,
  input  logic              q_full,
  output logic              q_push,
  output bkc_pkg::request_t q_data,
  input  logic              pkt_done,
  input  logic [$clog2(PAYLOAD_BYTES)-1:0] pb_raddr,
  output logic [7:0]        pb_rdata
);

  localparam int BPW = $clog2(PAYLOAD_BYTES + 1);
  localparam int NSW = $clog2(PAYLOAD_BYTES + 255);

  logic [7:0] pb_mem [PAYLOAD_BYTES];

  logic [BPW-1:0] byte_position, byte_position_next;
  logic [NSW-1:0] next_start, next_start_next;
  logic [7:0]     pending_length, pending_length_next;
  logic [7:0]     last_type, last_type_next;
  logic           found, found_next;
  logic [15:0]    found_key, found_key_next;
  logic           pkt_lock;

  logic           accept;
  logic           is_byte;
  logic           fin_found;
  logic [15:0]    fin_key;
  logic [7:0]     fin_type;

  assign accept  = start && !busy;
  assign is_byte = (bkc_pkg::kind_t'(kind) == bkc_pkg::KIND_BYTE);
  assign busy    = q_full || pkt_lock;
  assign q_push  = accept && (!is_byte || last);

  always_comb begin
    byte_position_next  = byte_position;
    next_start_next     = next_start;
    pending_length_next = pending_length;
    last_type_next      = last_type;
    found_next          = found;
    found_key_next      = found_key;
    if (byte_position < BPW'(PAYLOAD_BYTES)) begin
      byte_position_next = byte_position + 1'b1;
      if (!found) begin
        if (NSW'(byte_position) == next_start + NSW'(1)) begin
          last_type_next = data_byte;
          if (data_byte != bkc_pkg::TYPE_FLAGS) begin
            found_next     = 1'b1;
            found_key_next = {data_byte, pending_length};
          end else begin
            next_start_next = next_start + NSW'(pending_length) + NSW'(1);
          end
        end
        if (!found_next && NSW'(byte_position) == next_start_next) begin
          pending_length_next = data_byte;
        end
      end
    end
  end

  always_comb begin
    fin_found = found_next;
    fin_key   = found_key_next;
    fin_type  = last_type_next;
    if (!found_next && next_start_next < NSW'(byte_position_next)) begin
      fin_found = 1'b1;
      fin_key   = {8'h00, pending_length_next};
      fin_type  = 8'h00;
    end
  end

  always_comb begin
    q_data              = '0;
    q_data.kind         = bkc_pkg::kind_t'(kind);
    q_data.address      = address;
    q_data.device_index = device_index;
    q_data.slot_index   = slot_index;
    q_data.byte_index   = byte_index;
    if (is_byte) begin
      q_data.key    = fin_found ? fin_key : 16'h0000;
      q_data.ptype  = fin_type;
      q_data.length = 8'(byte_position_next);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_byte && byte_position < BPW'(PAYLOAD_BYTES)) begin
      pb_mem[byte_position[$clog2(PAYLOAD_BYTES)-1:0]] <= data_byte;
    end
    pb_rdata <= pb_mem[pb_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      next_start     <= '0;
      pending_length <= '0;
      last_type      <= '0;
      found          <= 1'b0;
      found_key      <= '0;
      pkt_lock       <= 1'b0;
    end else begin
      if (pkt_done) begin
        pkt_lock <= 1'b0;
      end
      if (accept && is_byte) begin
        if (last) begin
          byte_position  <= '0;
          next_start     <= '0;
          pending_length <= '0;
          last_type      <= '0;
          found          <= 1'b0;
          found_key      <= '0;
          pkt_lock       <= 1'b1;
        end else begin
          byte_position  <= byte_position_next;
          next_start     <= next_start_next;
          pending_length <= pending_length_next;
          last_type      <= last_type_next;
          found          <= found_next;
          found_key      <= found_key_next;
        end
      end
    end
  end

endmodule

[hdl/bkc_back.sv]
// Back sequencer: address table loads, device lookup, slot search and allocation, payload copy, reads and clears.
`include "assert_macros.svh"
module bkc_back #(
  parameter int DEVICES          = 64,
  parameter int SLOTS_PER_DEVICE = 16,
  parameter int PAYLOAD_BYTES    = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  input  logic              q_empty,
  input  bkc_pkg::request_t q_head,
  output logic              q_pop,
  output logic [$clog2(PAYLOAD_BYTES)-1:0] pb_raddr,
  input  logic [7:0]        pb_rdata,
  output logic              pkt_done,
  output logic              done,
  output logic [2:0]        status,
  output logic [15:0]       key,
  output logic [5:0]        device_slot,
  output logic [3:0]        key_slot,
  output logic [15:0]       hits,
  output logic [7:0]        read_byte,
  output logic [4:0]        read_length,
  output logic [4:0]        slots_in_use
);

  localparam int DW  = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int SW  = (SLOTS_PER_DEVICE > 1) ? $clog2(SLOTS_PER_DEVICE) : 1;
  localparam int UW  = $clog2(SLOTS_PER_DEVICE + 1);
  localparam int IW  = (DEVICES * SLOTS_PER_DEVICE > 1) ?
                       $clog2(DEVICES * SLOTS_PER_DEVICE) : 1;
  localparam int PAW = $clog2(DEVICES * SLOTS_PER_DEVICE * PAYLOAD_BYTES);
  localparam int SP  = SLOTS_PER_DEVICE * PAYLOAD_BYTES;
  localparam int PBW = $clog2(PAYLOAD_BYTES);

  logic [47:0]                 table_mem [DEVICES];
  logic [UW-1:0]               used_mem  [DEVICES];
  logic [DEVICES-1:0]          used_valid;
  bkc_pkg::slot_entry_t        slot_mem  [DEVICES * SLOTS_PER_DEVICE];
  logic [7:0]                  pay_mem   [DEVICES * SLOTS_PER_DEVICE * PAYLOAD_BYTES];

  logic [47:0]          table_q;
  logic [UW-1:0]        used_q;
  logic                 used_v_q;
  bkc_pkg::slot_entry_t slot_q;
  logic [7:0]           pay_q;

  bkc_pkg::back_state_t st, st_next;
  bkc_pkg::request_t    req;
  logic [6:0]           device_count;
  logic [DW-1:0]        dev;
  logic [8:0]           dcount;
  logic [UW-1:0]        used;
  logic [UW-1:0]        slot;
  logic [7:0]           bcnt;
  logic [7:0]           blimit;

  logic [8:0]           n_dev;
  logic                 dev_ok;
  logic                 is_name;
  logic                 addr_match;
  logic                 key_match;
  logic                 slot_in_range;
  logic                 lookup_last;
  logic                 copy_last;
  logic                 full_slots;
  logic [UW-1:0]        used_eff;
  logic [15:0]          hits_new;
  logic                 read_hit;

  logic [DW-1:0]        rd_dev;
  logic [6:0]           rd_slot;
  logic [4:0]           rd_byte;
  logic [IW-1:0]        slot_addr;
  logic [PAW-1:0]       pay_addr;
  logic                 table_we;
  logic                 slot_we;
  bkc_pkg::slot_entry_t slot_wdata;
  logic                 used_we;
  logic                 pay_we;
  logic [7:0]           pay_wdata;

  assign n_dev       = (9'(device_count) > 9'(DEVICES)) ? 9'(DEVICES) : 9'(device_count);
  assign dev_ok      = 9'(req.device_index) < 9'(DEVICES);
  assign is_name     = (req.ptype == bkc_pkg::TYPE_SHORT_NAME) ||
                       (req.ptype == bkc_pkg::TYPE_FULL_NAME);
  assign addr_match  = (table_q == req.address);
  assign key_match   = (slot_q.key == req.key);
  assign slot_in_range = (slot < used) && (slot < UW'(SLOTS_PER_DEVICE));
  assign lookup_last = (dcount + 9'd1) >= n_dev;
  assign copy_last   = (bcnt + 8'd1) >= blimit;
  assign full_slots  = used >= UW'(SLOTS_PER_DEVICE);
  assign used_eff    = used_v_q ? used_q : '0;
  assign hits_new    = (slot_q.hits == bkc_pkg::HITS_MAX) ? bkc_pkg::HITS_MAX :
                       slot_q.hits + 16'd1;
  assign read_hit    = (7'(req.slot_index) < 7'(used_eff)) &&
                       (7'(req.slot_index) < 7'(SLOTS_PER_DEVICE));
  assign pkt_done    = done && (req.kind == bkc_pkg::KIND_BYTE);

  always_comb begin
    st_next = st;
    unique case (st)
      bkc_pkg::B_IDLE: begin
        if (!q_empty) st_next = bkc_pkg::B_DISPATCH;
      end
      bkc_pkg::B_DISPATCH: begin
        unique case (req.kind)
          bkc_pkg::KIND_LOAD, bkc_pkg::KIND_CLEAR: st_next = bkc_pkg::B_IDLE;
          bkc_pkg::KIND_READ: st_next = dev_ok ? bkc_pkg::B_READ_WAIT : bkc_pkg::B_IDLE;
          bkc_pkg::KIND_BYTE: begin
            if (is_name || req.key == 16'h0000 || n_dev == 9'd0) begin
              st_next = bkc_pkg::B_IDLE;
            end else begin
              st_next = bkc_pkg::B_LOOKUP_RD;
            end
          end
          default: st_next = bkc_pkg::B_IDLE;
        endcase
      end
      bkc_pkg::B_READ_WAIT:  st_next = bkc_pkg::B_IDLE;
      bkc_pkg::B_LOOKUP_RD:  st_next = bkc_pkg::B_LOOKUP_CMP;
      bkc_pkg::B_LOOKUP_CMP: begin
        if (addr_match) begin
          st_next = bkc_pkg::B_USED_RD;
        end else if (lookup_last) begin
          st_next = bkc_pkg::B_IDLE;
        end else begin
          st_next = bkc_pkg::B_LOOKUP_RD;
        end
      end
      bkc_pkg::B_USED_RD:    st_next = bkc_pkg::B_SLOT_START;
      bkc_pkg::B_SLOT_START: st_next = bkc_pkg::B_SLOT_CHECK;
      bkc_pkg::B_SLOT_CHECK: begin
        st_next = slot_in_range ? bkc_pkg::B_SLOT_CMP : bkc_pkg::B_DECIDE;
      end
      bkc_pkg::B_SLOT_CMP: begin
        st_next = key_match ? bkc_pkg::B_COPY_RD : bkc_pkg::B_SLOT_CHECK;
      end
      bkc_pkg::B_DECIDE: begin
        st_next = full_slots ? bkc_pkg::B_IDLE : bkc_pkg::B_COPY_RD;
      end
      bkc_pkg::B_COPY_RD: st_next = bkc_pkg::B_COPY_WR;
      bkc_pkg::B_COPY_WR: st_next = copy_last ? bkc_pkg::B_IDLE : bkc_pkg::B_COPY_RD;
      default: st_next = bkc_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (st == bkc_pkg::B_IDLE) && !q_empty;
    rd_dev     = dev;
    rd_slot    = 7'(slot);
    rd_byte    = 5'(bcnt);
    if (st == bkc_pkg::B_DISPATCH) begin
      rd_dev  = DW'(req.device_index);
      rd_slot = 7'(req.slot_index);
      rd_byte = req.byte_index;
    end
    slot_addr  = IW'(rd_dev) * IW'(SLOTS_PER_DEVICE) + IW'(rd_slot);
    pay_addr   = PAW'(rd_dev) * PAW'(SP) + PAW'(rd_slot) * PAW'(PAYLOAD_BYTES) +
                 PAW'(rd_byte);
    pb_raddr   = bcnt[PBW-1:0];
    table_we   = (st == bkc_pkg::B_DISPATCH) && (req.kind == bkc_pkg::KIND_LOAD) && dev_ok;
    slot_we    = 1'b0;
    slot_wdata = '{key: req.key, hits: 16'd1, length: req.length};
    used_we    = 1'b0;
    if (st == bkc_pkg::B_SLOT_CMP && key_match) begin
      slot_we         = 1'b1;
      slot_wdata.hits = hits_new;
    end
    if (st == bkc_pkg::B_DECIDE && !full_slots) begin
      slot_we = 1'b1;
      used_we = 1'b1;
    end
    pay_we     = (st == bkc_pkg::B_COPY_WR);
    pay_wdata  = (bcnt < req.length) ? pb_rdata : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (table_we) table_mem[DW'(req.device_index)] <= req.address;
    table_q <= table_mem[dcount[DW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[dev] <= used + 1'b1;
    used_q <= used_mem[rd_dev];
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_addr] <= slot_wdata;
    slot_q <= slot_mem[slot_addr];
  end

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[pay_addr] <= pay_wdata;
    pay_q <= pay_mem[pay_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= bkc_pkg::B_IDLE;
      device_count <= '0;
      used_valid   <= '0;
      used_v_q     <= 1'b0;
      done         <= 1'b0;
    end else begin
      st       <= st_next;
      done     <= 1'b0;
      used_v_q <= used_valid[rd_dev];
      if (cfg_we) device_count <= cfg_wdata;
      if (st == bkc_pkg::B_DISPATCH && req.kind == bkc_pkg::KIND_CLEAR) begin
        used_valid <= '0;
      end
      if (used_we) used_valid[dev] <= 1'b1;
      unique case (st)
        bkc_pkg::B_DISPATCH: begin
          if (req.kind == bkc_pkg::KIND_READ && !dev_ok) done <= 1'b1;
          if (req.kind == bkc_pkg::KIND_BYTE &&
              (is_name || req.key == 16'h0000 || n_dev == 9'd0)) begin
            done <= 1'b1;
          end
        end
        bkc_pkg::B_READ_WAIT: done <= 1'b1;
        bkc_pkg::B_LOOKUP_CMP: begin
          if (!addr_match && lookup_last) done <= 1'b1;
        end
        bkc_pkg::B_DECIDE: begin
          if (full_slots) done <= 1'b1;
        end
        bkc_pkg::B_COPY_WR: begin
          if (copy_last) done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st)
      bkc_pkg::B_IDLE: begin
        if (!q_empty) req <= q_head;
      end
      bkc_pkg::B_DISPATCH: begin
        dcount       <= '0;
        status       <= bkc_pkg::ST_READ;
        key          <= '0;
        device_slot  <= '0;
        key_slot     <= '0;
        hits         <= '0;
        read_byte    <= '0;
        read_length  <= '0;
        slots_in_use <= '0;
        if (req.kind == bkc_pkg::KIND_BYTE) begin
          if (is_name) begin
            status <= bkc_pkg::ST_NAME;
            key    <= req.key;
          end else if (req.key == 16'h0000) begin
            status <= bkc_pkg::ST_NO_KEY;
          end else begin
            status <= bkc_pkg::ST_UNKNOWN;
            key    <= req.key;
          end
        end
      end
      bkc_pkg::B_READ_WAIT: begin
        status       <= bkc_pkg::ST_READ;
        key          <= read_hit ? slot_q.key : 16'h0000;
        device_slot  <= req.device_index;
        key_slot     <= req.slot_index;
        hits         <= read_hit ? slot_q.hits : 16'h0000;
        read_byte    <= (read_hit && 8'(req.byte_index) < 8'(PAYLOAD_BYTES)) ? pay_q : 8'h00;
        read_length  <= read_hit ? 5'(slot_q.length) : 5'd0;
        slots_in_use <= 5'(used_eff);
      end
      bkc_pkg::B_LOOKUP_CMP: begin
        if (addr_match) begin
          dev <= dcount[DW-1:0];
        end else begin
          dcount <= dcount + 9'd1;
        end
      end
      bkc_pkg::B_SLOT_START: begin
        used <= used_eff;
        slot <= '0;
      end
      bkc_pkg::B_SLOT_CMP: begin
        if (key_match) begin
          status       <= bkc_pkg::ST_UPDATED;
          key          <= req.key;
          device_slot  <= 6'(dev);
          key_slot     <= 4'(slot);
          hits         <= hits_new;
          read_length  <= 5'(req.length);
          slots_in_use <= 5'(used);
          bcnt         <= '0;
          blimit       <= req.length;
        end else begin
          slot <= slot + 1'b1;
        end
      end
      bkc_pkg::B_DECIDE: begin
        key          <= req.key;
        device_slot  <= 6'(dev);
        if (full_slots) begin
          status       <= bkc_pkg::ST_FULL;
          slots_in_use <= 5'(used);
        end else begin
          status       <= bkc_pkg::ST_CREATED;
          key_slot     <= 4'(slot);
          hits         <= 16'd1;
          read_length  <= 5'(req.length);
          slots_in_use <= 5'(used + 1'b1);
          bcnt         <= '0;
          blimit       <= 8'(PAYLOAD_BYTES);
        end
      end
      bkc_pkg::B_COPY_WR: bcnt <= bcnt + 8'd1;
      default: ;
    endcase
  end

  `BKC_ASSERT(result_single_cycle, done |=> !done)
  `BKC_NEVER(pop_only_when_idle, q_pop && st != bkc_pkg::B_IDLE)

endmodule

[hdl/ble_advert_key_collator_core.sv]
// Top level of the advertising key collator: front parser, request queue, back sequencer.
//
//  channel   direction  handshake           fields
//  request   in         start / busy        kind address data_byte last device_index
//                                           slot_index byte_index
//  result    out        done (one cycle)    status key device_slot key_slot hits
//                                           read_byte read_length slots_in_use
//  config    in         cfg_we              cfg_wdata (device_count)
//
// A non-final packet byte is taken by the front parser alone and is not queued.
// Load and clear end in dispatch; a read passes dispatch and read-wait before its result.
// A final byte scans up to min(device_count, DEVICES) address table entries, compares
// keys over the used slots and copies up to PAYLOAD_BYTES bytes, one memory port each.
// busy is high while the queue is full or a finished packet still owns the packet buffer.
// Reset is synchronous; slot counts are cleared at once through per-device valid bits.
module ble_advert_key_collator_core #(
  parameter int DEVICES          = 64,
  parameter int SLOTS_PER_DEVICE = 16,
  parameter int PAYLOAD_BYTES    = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [47:0] address,
  input  logic [7:0]  data_byte,
  input  logic        last,
  input  logic [5:0]  device_index,
  input  logic [3:0]  slot_index,
  input  logic [4:0]  byte_index,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] key,
  output logic [5:0]  device_slot,
  output logic [3:0]  key_slot,
  output logic [15:0] hits,
  output logic [7:0]  read_byte,
  output logic [4:0]  read_length,
  output logic [4:0]  slots_in_use
);

  logic              q_push;
  bkc_pkg::request_t q_data;
  logic              q_pop;
  bkc_pkg::request_t q_head;
  logic              q_empty;
  logic              q_full;
  logic              pkt_done;
  logic [$clog2(PAYLOAD_BYTES)-1:0] pb_raddr;
  logic [7:0]        pb_rdata;

  bkc_front #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .address(address),
    .data_byte(data_byte), .last(last), .device_index(device_index),
    .slot_index(slot_index), .byte_index(byte_index), .q_full(q_full),
    .q_push(q_push), .q_data(q_data), .pkt_done(pkt_done),
    .pb_raddr(pb_raddr), .pb_rdata(pb_rdata)
  );

  bkc_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .push_data(q_data), .pop(q_pop),
    .head(q_head), .empty(q_empty), .full(q_full)
  );

  bkc_back #(
    .DEVICES(DEVICES),
    .SLOTS_PER_DEVICE(SLOTS_PER_DEVICE),
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_back (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .q_empty(q_empty), .q_head(q_head), .q_pop(q_pop),
    .pb_raddr(pb_raddr), .pb_rdata(pb_rdata), .pkt_done(pkt_done), .done(done),
    .status(status), .key(key), .device_slot(device_slot), .key_slot(key_slot),
    .hits(hits), .read_byte(read_byte), .read_length(read_length),
    .slots_in_use(slots_in_use)
  );

endmodule

[tb/sv/ble_advert_key_collator_core_test.sv]
// Self-checking testbench of the advertising key collator core with a built-in predictor.
module ble_advert_key_collator_core_test;
  import bkc_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [47:0] address;
    logic [7:0]  data_byte;
    logic        last;
    logic [5:0]  device_index;
    logic [3:0]  slot_index;
    logic [4:0]  byte_index;
  } request_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] key;
    logic [5:0]  device_slot;
    logic [3:0]  key_slot;
    logic [15:0] hits;
    logic [7:0]  read_byte;
    logic [4:0]  read_length;
    logic [4:0]  slots_in_use;
  } collator_result_t;

  localparam int NUM_DEVICES = 64;
  localparam int NUM_SLOTS = 16;
  localparam int MAX_PAYLOAD = 31;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = 2'd0;
  logic [47:0] address = '0;
  logic [7:0] data_byte = '0;
  logic last = 1'b0;
  logic [5:0] device_index = '0;
  logic [3:0] slot_index = '0;
  logic [4:0] byte_index = '0;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_wdata = '0;
  logic done;
  logic [2:0] status;
  logic [15:0] key;
  logic [5:0] device_slot;
  logic [3:0] key_slot;
  logic [15:0] hits;
  logic [7:0] read_byte;
  logic [4:0] read_length;
  logic [4:0] slots_in_use;

  ble_advert_key_collator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind), .address(address),
    .data_byte(data_byte), .last(last), .device_index(device_index),
    .slot_index(slot_index), .byte_index(byte_index), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .done(done), .status(status), .key(key),
    .device_slot(device_slot), .key_slot(key_slot), .hits(hits), .read_byte(read_byte),
    .read_length(read_length), .slots_in_use(slots_in_use)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic [47:0] known_addr[NUM_DEVICES];
  int          used_count[NUM_DEVICES];
  logic [15:0] key_store[NUM_DEVICES*NUM_SLOTS];
  logic [15:0] hit_store[NUM_DEVICES*NUM_SLOTS];
  int          len_store[NUM_DEVICES*NUM_SLOTS];
  logic [7:0]  payload_store[NUM_DEVICES*NUM_SLOTS][MAX_PAYLOAD];
  logic [7:0]  packet_bytes[MAX_PAYLOAD];
  int          byte_pos;
  int          struct_start;
  logic [7:0]  pending_len;
  logic [7:0]  seen_type;
  logic        key_found;
  logic [15:0] found_key;
  int          table_limit;

  request_item_t    pending_requests[$];
  collator_result_t expected_results[$];
  request_item_t    current_request;
  int mismatches = 0;
  int stall_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int item_count = 0;
  logic [47:0] table_addr[NUM_DEVICES];

  function automatic void clear_assembly();
    byte_pos = 0;
    struct_start = 0;
    pending_len = '0;
    seen_type = '0;
    key_found = 1'b0;
    found_key = '0;
  endfunction

  function automatic void close_packet(logic [47:0] addr);
    int len, n, dev, slot, idx;
    logic [15:0] k;
    logic [7:0] t;
    collator_result_t r;
    len = byte_pos;
    if (!key_found && struct_start < len) begin
      seen_type = '0;
      key_found = 1'b1;
      found_key = {8'h00, pending_len};
    end
    k = found_key;
    t = seen_type;
    clear_assembly();
    r = '0;
    if (t == TYPE_SHORT_NAME || t == TYPE_FULL_NAME) begin
      r.status = ST_NAME;
      r.key = k;
    end else if (k == 16'h0000) begin
      r.status = ST_NO_KEY;
    end else begin
      n = table_limit > NUM_DEVICES ? NUM_DEVICES : table_limit;
      dev = -1;
      for (int d = 0; d < n; d++)
        if (dev < 0 && known_addr[d] == addr) dev = d;
      r.key = k;
      if (dev < 0) begin
        r.status = ST_UNKNOWN;
      end else begin
        slot = -1;
        for (int s = 0; s < used_count[dev]; s++)
          if (slot < 0 && key_store[dev*NUM_SLOTS+s] == k) slot = s;
        r.device_slot = dev;
        if (slot >= 0) begin
          idx = dev * NUM_SLOTS + slot;
          for (int i = 0; i < len; i++) payload_store[idx][i] = packet_bytes[i];
          len_store[idx] = len;
          if (hit_store[idx] != HITS_MAX) hit_store[idx]++;
          r.status = ST_UPDATED;
          r.key_slot = slot;
          r.hits = hit_store[idx];
          r.read_length = len;
          r.slots_in_use = used_count[dev];
        end else if (used_count[dev] >= NUM_SLOTS) begin
          r.status = ST_FULL;
          r.slots_in_use = used_count[dev];
        end else begin
          slot = used_count[dev];
          used_count[dev]++;
          idx = dev * NUM_SLOTS + slot;
          for (int i = 0; i < MAX_PAYLOAD; i++)
            payload_store[idx][i] = i < len ? packet_bytes[i] : 8'h00;
          key_store[idx] = k;
          len_store[idx] = len;
          hit_store[idx] = 16'd1;
          r.status = ST_CREATED;
          r.key_slot = slot;
          r.hits = 16'd1;
          r.read_length = len;
          r.slots_in_use = used_count[dev];
        end
      end
    end
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(request_item_t q);
    int p, idx;
    collator_result_t r;
    case (q.kind)
      KIND_LOAD: known_addr[q.device_index] = q.address;
      KIND_CLEAR: for (int d = 0; d < NUM_DEVICES; d++) used_count[d] = 0;
      KIND_READ: begin
        r = '0;
        r.status = ST_READ;
        r.device_slot = q.device_index;
        r.key_slot = q.slot_index;
        r.slots_in_use = used_count[q.device_index];
        if (q.slot_index < used_count[q.device_index]) begin
          idx = q.device_index * NUM_SLOTS + q.slot_index;
          r.key = key_store[idx];
          r.hits = hit_store[idx];
          r.read_length = len_store[idx];
          if (q.byte_index < MAX_PAYLOAD) r.read_byte = payload_store[idx][q.byte_index];
        end
        expected_results.push_back(r);
      end
      default: begin
        p = byte_pos;
        if (p < MAX_PAYLOAD) begin
          packet_bytes[p] = q.data_byte;
          byte_pos = p + 1;
          if (!key_found) begin
            if (p == struct_start + 1) begin
              seen_type = q.data_byte;
              if (q.data_byte != TYPE_FLAGS) begin
                key_found = 1'b1;
                found_key = {q.data_byte, pending_len};
              end else begin
                struct_start = struct_start + pending_len + 1;
              end
            end
            if (!key_found && p == struct_start) pending_len = q.data_byte;
          end
        end
        if (q.last) close_packet(q.address);
      end
    endcase
  endfunction

  function automatic request_item_t random_request(kind_t k);
    request_item_t q;
    q.kind = k;
    q.address = {$urandom, $urandom};
    q.data_byte = $urandom;
    q.last = $urandom;
    q.device_index = $urandom;
    q.slot_index = $urandom;
    q.byte_index = $urandom;
    return q;
  endfunction

  task automatic queue_load(int dev, logic [47:0] addr);
    request_item_t q;
    q = random_request(KIND_LOAD);
    q.device_index = dev;
    q.address = addr;
    table_addr[dev] = addr;
    pending_requests.push_back(q);
    item_count++;
  endtask

  task automatic queue_read(int dev, int slot, int pos);
    request_item_t q;
    q = random_request(KIND_READ);
    q.device_index = dev;
    q.slot_index = slot;
    q.byte_index = pos;
    pending_requests.push_back(q);
    item_count++;
  endtask

  task automatic queue_clear();
    pending_requests.push_back(random_request(KIND_CLEAR));
    item_count++;
  endtask

  task automatic queue_packet(logic [47:0] addr, logic [7:0] bytes[$], bit mixed);
    request_item_t q;
    for (int i = 0; i < bytes.size(); i++) begin
      q = random_request(KIND_BYTE);
      q.address = addr;
      q.data_byte = bytes[i];
      q.last = (i == bytes.size() - 1);
      pending_requests.push_back(q);
      item_count++;
      if (mixed && $urandom_range(0, 9) == 0)
        queue_read($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31));
    end
  endtask

  function automatic logic [47:0] pick_address();
    int c;
    c = $urandom_range(0, 9);
    if (c < 6) return table_addr[$urandom_range(0, 5)];
    if (c < 8) return table_addr[$urandom_range(0, 63)];
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random_packet();
    logic [7:0] b[$];
    int c, ln;
    c = $urandom_range(0, 19);
    if (c < 2) begin
      ln = $urandom_range(1, 8);
      repeat (ln) b.push_back($urandom);
    end else if (c < 3) begin
      ln = $urandom_range(28, 40);
      repeat (ln) b.push_back($urandom);
    end else begin
      if ($urandom_range(0, 1)) begin
        b.push_back(8'h02);
        b.push_back(TYPE_FLAGS);
        b.push_back($urandom);
      end else if ($urandom_range(0, 5) == 0) begin
        b.push_back(8'h00);
        b.push_back(TYPE_FLAGS);
      end
      ln = $urandom_range(1, 4);
      b.push_back(ln);
      case ($urandom_range(0, 9))
        0: b.push_back(TYPE_SHORT_NAME);
        1: b.push_back(TYPE_FULL_NAME);
        2: b.push_back($urandom);
        default: b.push_back(8'h10 + $urandom_range(0, 5));
      endcase
      repeat ($urandom_range(0, 6)) b.push_back($urandom);
      if ($urandom_range(0, 7) == 0) b = b[0:b.size()-2];
    end
    queue_packet(pick_address(), b, 1'b1);
  endtask

  task automatic wait_idle();
    wait (pending_requests.size() == 0 && expected_results.size() == 0 && !start);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_device_count(int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    table_limit = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(int count);
    int target;
    target = item_count + count;
    while (item_count < target) begin
      case ($urandom_range(0, 59))
        0: queue_clear();
        1, 2: queue_load($urandom_range(0, 63), $urandom_range(0, 1) ?
                         {$urandom, $urandom} : table_addr[$urandom_range(0, 63)]);
        3, 4, 5, 6, 7:
          queue_read($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31));
        default: queue_random_packet();
      endcase
    end
  endtask

  // Sender: bursts of requests separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_request(current_request);
      if (start && busy) begin
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
        current_request = pending_requests.pop_front();
        kind <= current_request.kind;
        address <= current_request.address;
        data_byte <= current_request.data_byte;
        last <= current_request.last;
        device_index <= current_request.device_index;
        slot_index <= current_request.slot_index;
        byte_index <= current_request.byte_index;
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 30);
          gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(5, 25) : $urandom_range(0, 3);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    collator_result_t got, want;
    if (!rst) begin
      if (done) begin
        got = {status, key, device_slot, key_slot, hits, read_byte, read_length, slots_in_use};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] b[$];
    logic [47:0] a0;
    for (int d = 0; d < NUM_DEVICES; d++) begin
      used_count[d] = 0;
      known_addr[d] = '0;
    end
    clear_assembly();
    table_limit = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int d = 0; d < NUM_DEVICES; d++)
      queue_load(d, d == 40 ? table_addr[5] : (d == 63 ? 48'hFFFF_FFFF_FFFF : {$urandom, $urandom}));
    wait_idle();
    write_device_count(NUM_DEVICES);

    a0 = table_addr[0];
    b = '{8'h02, 8'h01, 8'h06, 8'h03, 8'hFF, 8'hAA, 8'h00};
    queue_packet(a0, b, 1'b0);
    queue_packet(a0, b, 1'b0);
    b = '{8'h03, 8'h09, 8'h41, 8'h42};
    queue_packet(a0, b, 1'b0);
    b = '{8'h00};
    queue_packet(a0, b, 1'b0);
    b = '{8'h02, 8'h01, 8'h06, 8'h05};
    queue_packet(a0, b, 1'b0);
    b = '{8'h00, 8'h01, 8'h03, 8'h16, 8'h11, 8'h22};
    queue_packet(a0, b, 1'b0);
    b = {};
    repeat (40) b.push_back(8'hFF);
    queue_packet(table_addr[63], b, 1'b0);
    b = '{8'h02, 8'h16, 8'h01};
    queue_packet(48'h0, b, 1'b0);
    queue_packet(table_addr[5], b, 1'b0);
    queue_read(0, 0, 0);
    queue_read(0, 0, 31);
    queue_read(0, 15, 30);
    queue_read(63, 0, 31);
    b = '{8'h04, 8'h08, 8'h61, 8'h62, 8'h63};
    queue_packet(table_addr[1], b, 1'b1);
    queue_clear();
    queue_read(0, 0, 0);
    wait_idle();

    write_device_count(127);
    run_random_phase(350);
    wait_idle();
    write_device_count(0);
    run_random_phase(100);
    wait_idle();
    write_device_count(1);
    run_random_phase(250);
    wait_idle();
    write_device_count($urandom_range(2, 63));
    run_random_phase(350);
    wait_idle();
    write_device_count(NUM_DEVICES);
    run_random_phase(350);
    wait_idle();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/bkc_pkg.sv
hdl/bkc_queue.sv
hdl/bkc_front.sv
hdl/bkc_back.sv
hdl/ble_advert_key_collator_core.sv
tb/sv/ble_advert_key_collator_core_test.sv
